[sv/sst_pkg.sv]
// Shared types and constants for the strongest source tracker.
package sst_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ADDRESS_BYTES = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int LEAVES = 1 << IDX_W;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = 8 * ADDRESS_BYTES;

   // Keep only the low address bytes of the 48-bit field
   localparam logic [47:0] ADDR_MASK = (ADDR_W >= 48) ? 48'hFFFF_FFFF_FFFF :
                                       ((48'd1 << ADDR_W) - 48'd1);

   localparam logic [7:0] ADVERT_TYPE = 8'h00;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QCNT_W-1:0] qcnt_type;

   typedef enum logic [1:0] {
      ST_UPDATED  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_DROPPED  = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  packet_type;
      logic [47:0] source_address;
      logic [7:0]  signal_strength;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  entry_slot;
      logic [4:0]  entries_used;
      logic        best_found;
      logic [47:0] best_address;
      logic [7:0]  best_strength;
   } rsp_type;

   // Classified request handed from the front to the back
   typedef struct packed {
      logic        advert;
      logic [47:0] address;
      logic [7:0]  strength;
   } cmd_type;

endpackage

[sv/strongest_source_tracker.sv]
// Top level of the strongest source tracker.
// Each advertisement request (packet type 0) looks up its source address in a
// table of up to 16 sources, overwrites the stored strength on a match or
// appends the source, or drops it when the table is full; other packet types
// leave the table alone. Every request yields one response with the outcome
// and the strongest stored source (lowest slot on ties, zero strength never
// wins). A request is held in the input register, passes a two-entry command
// queue, and is then handled by the table sequencer (fetch, match and write,
// maximum search), which takes a new request only when it is through with the
// last one. The response register lets the next request be fetched and
// matched while a response waits to be popped; its report waits for the pop.
module strongest_source_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sst_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sst_pkg::rsp_type rsp_data
);

   logic             f_push, q_full, q_empty, q_pop;
   sst_pkg::cmd_type f_data, q_data;

   sst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (f_push),
      .q_full   (q_full),
      .q_data   (f_data)
   );

   sst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .full     (q_full),
      .data_in  (f_data),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_data)
   );

   sst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/sst_front.sv]
// Input register that accepts requests and classifies them into commands.
module sst_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  sst_pkg::req_type req_data,
   output logic            q_push,
   input  logic            q_full,
   output sst_pkg::cmd_type q_data
);

   logic             valid_ff, valid_in;
   sst_pkg::cmd_type cmd_ff, cmd_in;
   logic             accept;

   // Stall only while the held command cannot enter the queue
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff;
   assign q_data   = cmd_ff;

   // Classify the request and mask the address
   always_comb begin
      valid_in = accept || (valid_ff && q_full);
      cmd_in   = cmd_ff;
      if (accept) begin
         cmd_in.advert   = (req_data.packet_type == sst_pkg::ADVERT_TYPE);
         cmd_in.address  = req_data.source_address & sst_pkg::ADDR_MASK;
         cmd_in.strength = req_data.signal_strength;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[sv/sst_queue.sv]
// Short command queue between the front and the back.
module sst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sst_pkg::cmd_type data_in,
   input  logic             pop,
   output logic             empty,
   output sst_pkg::cmd_type data_out
);

   sst_pkg::cmd_type  slot_ff [sst_pkg::QUEUE_DEPTH];
   sst_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   sst_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   sst_pkg::qcnt_type count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == sst_pkg::qcnt_type'(sst_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   // Advance the pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sst_pkg::qptr_type'(sst_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sst_pkg::qptr_type'(sst_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

[sv/sst_back.sv]
// Source table with parallel address match, update and strongest-entry search.
module sst_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   output logic             q_pop,
   input  sst_pkg::cmd_type q_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output sst_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_MATCH,
      B_BEST
   } state_type;

   typedef struct packed {
      logic [7:0]  strength;
      logic [47:0] address;
   } cand_type;

   state_type            state_ff, state_in;
   sst_pkg::cmd_type     cmd_ff, cmd_in;
   sst_pkg::status_type  status_ff, status_in;
   sst_pkg::idx_type     slot_ff, slot_in;
   sst_pkg::cnt_type     count_ff, count_in;
   logic                 out_valid_ff, out_valid_in;
   sst_pkg::rsp_type     out_ff, out_in;

   logic [47:0]          addr_ff [sst_pkg::TABLE_ENTRIES];
   logic [7:0]           str_ff  [sst_pkg::TABLE_ENTRIES];

   logic [sst_pkg::TABLE_ENTRIES-1:0] match;
   logic                 hit;
   sst_pkg::idx_type     hit_idx;
   logic                 wr_en;
   logic                 wr_new;
   sst_pkg::idx_type     wr_idx;
   cand_type             node [2*sst_pkg::LEAVES];
   logic                 out_free;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   // Compare the address against every valid entry
   always_comb begin
      for (int i = 0; i < sst_pkg::TABLE_ENTRIES; i++) begin
         match[i] = (sst_pkg::cnt_type'(i) < count_ff) && (addr_ff[i] == cmd_ff.address);
      end
   end

   // Pick the lowest matching slot
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = sst_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = sst_pkg::idx_type'(i);
         end
      end
   end

   // Maximum tree: invalid entries count as zero, ties keep the left side
   always_comb begin
      for (int j = 0; j < sst_pkg::LEAVES; j++) begin
         if (j < sst_pkg::TABLE_ENTRIES && sst_pkg::cnt_type'(j) < count_ff) begin
            node[sst_pkg::LEAVES + j].strength = str_ff[j];
            node[sst_pkg::LEAVES + j].address  = addr_ff[j];
         end else begin
            node[sst_pkg::LEAVES + j] = '0;
         end
      end
      node[0] = '0;
      for (int n = sst_pkg::LEAVES - 1; n >= 1; n--) begin
         node[n] = (node[2*n+1].strength > node[2*n].strength) ? node[2*n+1] : node[2*n];
      end
   end

   // Sequence one command: fetch, match and write, then report the best entry
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_new       = 1'b0;
      wr_idx       = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               cmd_in   = q_data;
               state_in = B_MATCH;
            end
         end
         B_MATCH: begin
            slot_in = '0;
            if (!cmd_ff.advert) begin
               status_in = sst_pkg::ST_IGNORED;
            end else if (hit) begin
               status_in = sst_pkg::ST_UPDATED;
               slot_in   = hit_idx;
               wr_en     = 1'b1;
               wr_idx    = hit_idx;
            end else if (count_ff < sst_pkg::cnt_type'(sst_pkg::TABLE_ENTRIES)) begin
               status_in = sst_pkg::ST_INSERTED;
               slot_in   = count_ff[sst_pkg::IDX_W-1:0];
               wr_en     = 1'b1;
               wr_new    = 1'b1;
               wr_idx    = count_ff[sst_pkg::IDX_W-1:0];
               count_in  = count_ff + 1'b1;
            end else begin
               status_in = sst_pkg::ST_DROPPED;
            end
            state_in = B_BEST;
         end
         B_BEST: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_in.status        = status_ff;
               out_in.entry_slot    = 4'(slot_ff);
               out_in.entries_used  = 5'(count_ff);
               out_in.best_found    = (node[1].strength != 8'd0);
               out_in.best_address  = (node[1].strength != 8'd0) ? node[1].address : 48'd0;
               out_in.best_strength = node[1].strength;
               state_in             = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      out_ff    <= out_in;
      if (wr_en) begin
         str_ff[wr_idx] <= cmd_ff.strength;
      end
      if (wr_new) begin
         addr_ff[wr_idx] <= cmd_ff.address;
      end
   end

   // The fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sst_pkg::cnt_type'(sst_pkg::TABLE_ENTRIES))
      else $error("table fill count above table size");

   // An ignored command leaves the fill count alone
   a_ignored_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MATCH && !cmd_ff.advert) |=> count_ff == $past(count_ff))
      else $error("ignored request changed the fill count");

   // A waiting result holds the sequencer in the search state
   a_best_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_BEST && out_valid_ff && !rsp_pop) |=> state_ff == B_BEST)
      else $error("result overwritten while still waiting");

   // A result without a best entry reports zero strength
   a_best_consistent: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.best_found) |-> out_ff.best_strength == 8'd0)
      else $error("best strength set without a best entry");

endmodule
